[hw/rtl/fxalu_pkg.sv]
package fxalu_pkg;

	localparam int FRAC_BITS  = 8;
	localparam int DATA_WIDTH = 32;
	localparam int INT_WIDTH  = DATA_WIDTH - FRAC_BITS;
	localparam int NUM_WIDTH  = DATA_WIDTH + FRAC_BITS;
	localparam int PROD_WIDTH = 2 * DATA_WIDTH;

	// action codes
	localparam logic [3:0] ACT_ADD  = 4'd0;
	localparam logic [3:0] ACT_SUB  = 4'd1;
	localparam logic [3:0] ACT_MUL  = 4'd2;
	localparam logic [3:0] ACT_DIV  = 4'd3;
	localparam logic [3:0] ACT_MIN  = 4'd4;
	localparam logic [3:0] ACT_MAX  = 4'd5;
	localparam logic [3:0] ACT_INC  = 4'd6;
	localparam logic [3:0] ACT_DEC  = 4'd7;
	localparam logic [3:0] ACT_LOAD = 4'd8;

	localparam logic signed [DATA_WIDTH-1:0] SAT_HI = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [DATA_WIDTH-1:0] SAT_LO = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	// result and flags carried alongside the divider
	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] res;
		logic                         ovf;
		logic                         dz;
		logic                         gt;
		logic                         lt;
		logic                         eq;
		logic [INT_WIDTH-1:0]         ipart;
		logic                         is_div;
		logic                         neg;
	} side_t;

	// one restoring divider step state
	typedef struct packed {
		logic [DATA_WIDTH-1:0] rem;
		logic [NUM_WIDTH-1:0]  dq;
		logic [DATA_WIDTH-1:0] mb;
	} div_t;

endpackage

[hw/rtl/fixed_point_alu_unit.sv]
// fixed-point Q24.8 alu, fully pipelined
// stages: input stage, one stage per quotient bit of the 40-bit restoring
// divider, output stage
// throughput: one transaction per cycle; the whole pipe holds while the
// output is valid and stalled
// reset: arst_n clears all valid bits asynchronously, payload is not reset
module fixed_point_alu_unit
	import fxalu_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [3:0]                   action,
	input  logic signed [DATA_WIDTH-1:0] operand_a,
	input  logic signed [DATA_WIDTH-1:0] operand_b,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [DATA_WIDTH-1:0] result_raw,
	output logic                         a_greater,
	output logic                         a_less,
	output logic                         a_equal,
	output logic signed [INT_WIDTH-1:0]  integer_part,
	output logic                         overflowed,
	output logic                         divide_by_zero
);

	localparam int NSTG = NUM_WIDTH;

	// one divider step: shift in a dividend bit, subtract when it fits
	function automatic div_t div_step(input div_t d);
		logic [DATA_WIDTH:0] t;
		logic [DATA_WIDTH:0] diff;
		div_t o;
		t    = {d.rem, d.dq[NUM_WIDTH-1]};
		diff = t - {1'b0, d.mb};
		o.mb = d.mb;
		if (t >= {1'b0, d.mb}) begin
			o.rem = diff[DATA_WIDTH-1:0];
			o.dq  = {d.dq[NUM_WIDTH-2:0], 1'b1};
		end else begin
			o.rem = t[DATA_WIDTH-1:0];
			o.dq  = {d.dq[NUM_WIDTH-2:0], 1'b0};
		end
		return o;
	endfunction

	logic adv;

	// global advance
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// stage 1: capture operands, multiply
	logic                          v_s1;
	logic [3:0]                    act_s1;
	logic signed [DATA_WIDTH-1:0]  a_s1;
	logic signed [DATA_WIDTH-1:0]  b_s1;
	logic signed [PROD_WIDTH-1:0]  prod_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s1  <= action;
			a_s1    <= operand_a;
			b_s1    <= operand_b;
			prod_s1 <= PROD_WIDTH'(operand_a) * PROD_WIDTH'(operand_b);
		end
	end

	// non-divide results, flags and divider setup from stage 1
	logic signed [DATA_WIDTH:0]   sum_w;
	logic signed [DATA_WIDTH:0]   dif_w;
	logic signed [DATA_WIDTH:0]   inc_w;
	logic signed [DATA_WIDTH:0]   dec_w;
	logic                         p_neg;
	logic [PROD_WIDTH-1:0]        p_mag;
	logic [PROD_WIDTH-1:0]        p_rnd;
	logic [DATA_WIDTH-1:0]        ma;
	logic [DATA_WIDTH-1:0]        mb;
	side_t                        side_n;
	div_t                         div_init;

	always_comb begin
		sum_w = {a_s1[DATA_WIDTH-1], a_s1} + {b_s1[DATA_WIDTH-1], b_s1};
		dif_w = {a_s1[DATA_WIDTH-1], a_s1} - {b_s1[DATA_WIDTH-1], b_s1};
		inc_w = {a_s1[DATA_WIDTH-1], a_s1} + (DATA_WIDTH+1)'(1);
		dec_w = {a_s1[DATA_WIDTH-1], a_s1} - (DATA_WIDTH+1)'(1);
		p_neg = prod_s1[PROD_WIDTH-1];
		p_mag = p_neg ? PROD_WIDTH'(-prod_s1) : PROD_WIDTH'(prod_s1);
		p_rnd = (p_mag + (PROD_WIDTH'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		ma    = a_s1[DATA_WIDTH-1] ? DATA_WIDTH'(-a_s1) : DATA_WIDTH'(a_s1);
		mb    = b_s1[DATA_WIDTH-1] ? DATA_WIDTH'(-b_s1) : DATA_WIDTH'(b_s1);

		side_n.gt     = a_s1 > b_s1;
		side_n.lt     = a_s1 < b_s1;
		side_n.eq     = a_s1 == b_s1;
		side_n.ipart  = a_s1[DATA_WIDTH-1:FRAC_BITS];
		side_n.is_div = 1'b0;
		side_n.neg    = a_s1[DATA_WIDTH-1] ^ b_s1[DATA_WIDTH-1];
		side_n.ovf    = 1'b0;
		side_n.dz     = 1'b0;
		side_n.res    = '0;

		case (act_s1)
			ACT_ADD: begin
				if (sum_w[DATA_WIDTH] != sum_w[DATA_WIDTH-1]) begin
					side_n.ovf = 1'b1;
					side_n.res = sum_w[DATA_WIDTH] ? SAT_LO : SAT_HI;
				end else begin
					side_n.res = sum_w[DATA_WIDTH-1:0];
				end
			end
			ACT_SUB: begin
				if (dif_w[DATA_WIDTH] != dif_w[DATA_WIDTH-1]) begin
					side_n.ovf = 1'b1;
					side_n.res = dif_w[DATA_WIDTH] ? SAT_LO : SAT_HI;
				end else begin
					side_n.res = dif_w[DATA_WIDTH-1:0];
				end
			end
			ACT_MUL: begin
				if (!p_neg && p_rnd > PROD_WIDTH'(SAT_HI)) begin
					side_n.ovf = 1'b1;
					side_n.res = SAT_HI;
				end else if (p_neg && p_rnd > (PROD_WIDTH'(1) << (DATA_WIDTH - 1))) begin
					side_n.ovf = 1'b1;
					side_n.res = SAT_LO;
				end else begin
					side_n.res = p_neg ? -$signed(p_rnd[DATA_WIDTH-1:0])
					                   : $signed(p_rnd[DATA_WIDTH-1:0]);
				end
			end
			ACT_DIV: begin
				if (b_s1 == '0) begin
					side_n.dz = 1'b1;
					if (a_s1 > 0) begin
						side_n.res = SAT_HI;
					end else if (a_s1 < 0) begin
						side_n.res = SAT_LO;
					end else begin
						side_n.res = '0;
					end
				end else begin
					side_n.is_div = 1'b1;
				end
			end
			ACT_MIN: begin
				side_n.res = (a_s1 < b_s1) ? a_s1 : b_s1;
			end
			ACT_MAX: begin
				side_n.res = (a_s1 > b_s1) ? a_s1 : b_s1;
			end
			ACT_INC: begin
				if (inc_w[DATA_WIDTH] != inc_w[DATA_WIDTH-1]) begin
					side_n.ovf = 1'b1;
					side_n.res = SAT_HI;
				end else begin
					side_n.res = inc_w[DATA_WIDTH-1:0];
				end
			end
			ACT_DEC: begin
				if (dec_w[DATA_WIDTH] != dec_w[DATA_WIDTH-1]) begin
					side_n.ovf = 1'b1;
					side_n.res = SAT_LO;
				end else begin
					side_n.res = dec_w[DATA_WIDTH-1:0];
				end
			end
			ACT_LOAD: begin
				if (a_s1[DATA_WIDTH-1:INT_WIDTH-1] != {(FRAC_BITS+1){a_s1[DATA_WIDTH-1]}}) begin
					side_n.ovf = 1'b1;
					side_n.res = a_s1[DATA_WIDTH-1] ? SAT_LO : SAT_HI;
				end else begin
					side_n.res = {a_s1[INT_WIDTH-1:0], {FRAC_BITS{1'b0}}};
				end
			end
			default: begin
				side_n.res = '0;
			end
		endcase

		div_init.rem = '0;
		div_init.dq  = {ma, {FRAC_BITS{1'b0}}};
		div_init.mb  = mb;
	end

	// divider pipeline, one quotient bit per stage
	logic  v_d  [NSTG];
	side_t sd_d [NSTG];
	div_t  dv_d [NSTG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_d[0] <= 1'b0;
		end else if (adv) begin
			v_d[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_d[0] <= side_n;
			dv_d[0] <= div_step(div_init);
		end
	end

	for (genvar k = 1; k < NSTG; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_d[k] <= 1'b0;
			end else if (adv) begin
				v_d[k] <= v_d[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sd_d[k] <= sd_d[k-1];
				dv_d[k] <= div_step(dv_d[k-1]);
			end
		end
	end

	// quotient rounding and saturation
	side_t                last;
	logic [NUM_WIDTH:0]   q_rnd;
	logic                 rnd_up;
	logic signed [DATA_WIDTH-1:0] res_n;
	logic                 ovf_n;

	always_comb begin
		last   = sd_d[NSTG-1];
		rnd_up = {dv_d[NSTG-1].rem, 1'b0} >= {1'b0, dv_d[NSTG-1].mb};
		q_rnd  = {1'b0, dv_d[NSTG-1].dq} + (NUM_WIDTH+1)'(rnd_up);
		res_n  = last.res;
		ovf_n  = last.ovf;
		if (last.is_div) begin
			if (!last.neg && q_rnd > (NUM_WIDTH+1)'(SAT_HI)) begin
				ovf_n = 1'b1;
				res_n = SAT_HI;
			end else if (last.neg && q_rnd > ((NUM_WIDTH+1)'(1) << (DATA_WIDTH - 1))) begin
				ovf_n = 1'b1;
				res_n = SAT_LO;
			end else begin
				res_n = last.neg ? -$signed(q_rnd[DATA_WIDTH-1:0])
				                 : $signed(q_rnd[DATA_WIDTH-1:0]);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= v_d[NSTG-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_raw     <= res_n;
			a_greater      <= last.gt;
			a_less         <= last.lt;
			a_equal        <= last.eq;
			integer_part   <= last.ipart;
			overflowed     <= ovf_n;
			divide_by_zero <= last.dz;
		end
	end

	// checks
	a_cmp_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot({a_greater, a_less, a_equal}))
		else $error("comparison flags not one-hot");

	a_dz_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_by_zero |-> !overflowed)
		else $error("divide by zero also flagged overflow");

	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflowed |-> (result_raw == SAT_HI || result_raw == SAT_LO))
		else $error("overflow without saturated result");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

endmodule
